// File: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers shared by the counter modules. In synthesis
// the macros expand to nothing.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property holds at every clock edge outside reset
`define EKD_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("%m: check failed");
// condition in one cycle implies consequence in the next
`define EKD_ASSERT_NEXT(label, clk, rst_n, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error("%m: check failed");
`else
`define EKD_ASSERT(label, clk, rst_n, prop)
`define EKD_ASSERT_NEXT(label, clk, rst_n, cond, cons)
`endif
`endif

// File: sv/ekd_pkg.sv
// ----------------------------------------------------------------------------
// ekd_pkg
// Shared widths, constants, controller states and the command and status
// bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package ekd_pkg;

    // parameter defaults
    localparam int DEF_MAX_LEN    = 1024;
    localparam int DEF_VALUE_BITS = 10;

    // fixed field widths
    localparam int CFG_BITS    = 11;
    localparam int ENDING_BITS = 11;
    localparam int TOTAL_BITS  = 20;

    // epoch tag kept with each frequency entry
    localparam int EPOCH_BITS = 8;

    localparam logic [CFG_BITS-1:0]    K_RESET    = 11'd1;
    localparam logic [ENDING_BITS-1:0] ENDING_MAX = 11'd2047;
    localparam logic [TOTAL_BITS-1:0]  TOTAL_MAX  = 20'd1048575;

    // controller states
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP,
        ST_PUSH,
        ST_CHK_W,
        ST_CHK_N,
        ST_RD_VAL,
        ST_RD_FREQ,
        ST_DEC,
        ST_GAP,
        ST_FINISH
    } ekd_state_t;

    // controller to datapath
    typedef struct packed {
        logic clear_wr;
        logic accept;
        logic lookup;
        logic push;
        logic rd_val;
        logic rd_freq;
        logic dec;
        logic win_n;
        logic gap;
        logic finish;
    } ekd_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clear_done;
        logic in_range;
        logic k_ge2;
        logic shrink_w;
        logic shrink_n;
        logic out_free;
        logic last;
        logic epoch_wrap;
    } ekd_status_t;

endpackage

// File: sv/ekd_if.sv
// ----------------------------------------------------------------------------
// ekd_if
// Valid/ready channels of the counter: input items, results and the
// configuration write channel.
// ----------------------------------------------------------------------------

// input item channel
interface ekd_in_if
    import ekd_pkg::*;
#(
    parameter int VALUE_BITS = DEF_VALUE_BITS
) ();
    logic                  valid;
    logic                  ready;
    logic [VALUE_BITS-1:0] value;
    logic                  last;

    modport source (output valid, output value, output last, input ready);
    modport sink   (input valid, input value, input last, output ready);
endinterface

// result channel
interface ekd_out_if
    import ekd_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic [ENDING_BITS-1:0] ending_here;
    logic [TOTAL_BITS-1:0]  running_total;
    logic                   overflow;
    logic                   done_res;

    modport source (output valid, output ending_here, output running_total,
                    output overflow, output done_res, input ready);
    modport sink   (input valid, input ending_here, input running_total,
                    input overflow, input done_res, output ready);
endinterface

// configuration write channel
interface ekd_cfg_if
    import ekd_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [CFG_BITS-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: sv/ekd_ctrl.sv
// ----------------------------------------------------------------------------
// ekd_ctrl
// Sequencer for one item: value lookup, window push, pointer shrink loop
// for each window, gap computation and result hand-off.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ekd_ctrl
    import ekd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  ekd_status_t status,
    output ekd_cmd_t    cmd
);

    ekd_state_t state_reg;
    ekd_state_t state_next;
    logic       win_n_reg;
    logic       win_n_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            win_n_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            win_n_reg <= win_n_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        win_n_next = win_n_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        cmd.win_n  = win_n_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_wr = 1'b1;
                if (status.clear_done)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                if (status.in_range)
                begin
                    cmd.lookup = 1'b1;
                    state_next = ST_PUSH;
                end
                else
                    state_next = ST_FINISH;
            end
            ST_PUSH:
            begin
                cmd.push   = 1'b1;
                state_next = ST_CHK_W;
            end
            ST_CHK_W:
            begin
                if (status.shrink_w)
                begin
                    win_n_next = 1'b0;
                    state_next = ST_RD_VAL;
                end
                else if (status.k_ge2)
                    state_next = ST_CHK_N;
                else
                    state_next = ST_GAP;
            end
            ST_CHK_N:
            begin
                if (status.shrink_n)
                begin
                    win_n_next = 1'b1;
                    state_next = ST_RD_VAL;
                end
                else
                    state_next = ST_GAP;
            end
            ST_RD_VAL:
            begin
                cmd.rd_val = 1'b1;
                state_next = ST_RD_FREQ;
            end
            ST_RD_FREQ:
            begin
                cmd.rd_freq = 1'b1;
                state_next  = ST_DEC;
            end
            ST_DEC:
            begin
                cmd.dec    = 1'b1;
                state_next = win_n_reg ? ST_CHK_N : ST_CHK_W;
            end
            ST_GAP:
            begin
                cmd.gap    = 1'b1;
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.finish = 1'b1;
                    if (status.last && status.epoch_wrap)
                        state_next = ST_CLEAR;
                    else
                        state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // one item in flight at a time
    `EKD_ASSERT_NEXT(a_one_item, clk, rst_n, cmd.accept, !in_ready)

endmodule

// File: sv/ekd_dp.sv
// ----------------------------------------------------------------------------
// ekd_dp
// Datapath: value store, two epoch-tagged frequency tables, window
// counters and pointers, running total and the result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ekd_dp
    import ekd_pkg::*;
#(
    parameter int MAX_LEN    = DEF_MAX_LEN,
    parameter int VALUE_BITS = DEF_VALUE_BITS
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  ekd_cmd_t              cmd,
    output ekd_status_t           status,
    input  logic [VALUE_BITS-1:0] in_value,
    input  logic                  in_last,
    ekd_cfg_if.sink               cfg,
    ekd_out_if.source             result
);

    localparam int PW     = $clog2(MAX_LEN + 1);
    localparam int AW     = $clog2(MAX_LEN);
    localparam int VDEPTH = 1 << VALUE_BITS;
    localparam int FW     = EPOCH_BITS + PW;
    localparam int CMPW   = (PW > CFG_BITS) ? PW : CFG_BITS;
    localparam int GW     = (PW > ENDING_BITS) ? PW : ENDING_BITS;
    localparam int XW     = PW + 1;

    // storage
    logic [VALUE_BITS-1:0] value_mem  [MAX_LEN];
    logic [FW-1:0]         freq_w_mem [VDEPTH];
    logic [FW-1:0]         freq_n_mem [VDEPTH];

    // registers
    logic [CFG_BITS-1:0]    k_reg;
    logic [VALUE_BITS-1:0]  value_reg;
    logic                   last_reg;
    logic                   in_range_reg;
    logic [PW-1:0]          position_reg;
    logic [PW-1:0]          left_w_reg;
    logic [PW-1:0]          left_n_reg;
    logic [PW-1:0]          distinct_w_reg;
    logic [PW-1:0]          distinct_n_reg;
    logic [TOTAL_BITS-1:0]  total_reg;
    logic                   ovf_reg;
    logic [EPOCH_BITS-1:0]  epoch_reg;
    logic [VALUE_BITS-1:0]  clr_addr_reg;
    logic [ENDING_BITS-1:0] ending_reg;
    logic [VALUE_BITS-1:0]  vs_rdata_reg;
    logic [FW-1:0]          fw_rdata_reg;
    logic [FW-1:0]          fn_rdata_reg;
    logic                   res_valid_reg;
    logic [ENDING_BITS-1:0] res_ending_reg;
    logic [TOTAL_BITS-1:0]  res_total_reg;
    logic                   res_ovf_reg;
    logic                   res_done_reg;

    // combinational
    logic [PW-1:0]          cnt_w;
    logic [PW-1:0]          cnt_n;
    logic [PW-1:0]          cnt_sel;
    logic [PW-1:0]          left_sel;
    logic [PW-1:0]          narrow_left;
    logic [PW-1:0]          gap;
    logic [GW-1:0]          gap_ext;
    logic [ENDING_BITS-1:0] ending_next;
    logic [TOTAL_BITS:0]    total_sum;
    logic [TOTAL_BITS-1:0]  total_next;
    logic                   k_ge2;
    logic                   fw_re;
    logic                   fn_re;
    logic                   fw_we;
    logic                   fn_we;
    logic [VALUE_BITS-1:0]  f_raddr;
    logic [VALUE_BITS-1:0]  f_waddr;
    logic [FW-1:0]          fw_wdata;
    logic [FW-1:0]          fn_wdata;

    assign cfg.ready = 1'b1;
    assign k_ge2     = |k_reg[CFG_BITS-1:1];

    // counts from a stale epoch read as zero
    assign cnt_w = (fw_rdata_reg[FW-1 -: EPOCH_BITS] == epoch_reg) ?
                   fw_rdata_reg[PW-1:0] : '0;
    assign cnt_n = (fn_rdata_reg[FW-1 -: EPOCH_BITS] == epoch_reg) ?
                   fn_rdata_reg[PW-1:0] : '0;
    assign cnt_sel  = cmd.win_n ? cnt_n : cnt_w;
    assign left_sel = cmd.win_n ? left_n_reg : left_w_reg;

    // frequency table port control
    always_comb
    begin
        f_raddr = cmd.lookup ? value_reg : vs_rdata_reg;
        fw_re   = cmd.lookup | (cmd.rd_freq & !cmd.win_n);
        fn_re   = cmd.lookup | (cmd.rd_freq & cmd.win_n);
        fw_we   = cmd.clear_wr | cmd.push | (cmd.dec & !cmd.win_n & (cnt_w != '0));
        fn_we   = cmd.clear_wr | (cmd.push & k_ge2)
                  | (cmd.dec & cmd.win_n & (cnt_n != '0));
        if (cmd.clear_wr)
            f_waddr = clr_addr_reg;
        else if (cmd.push)
            f_waddr = value_reg;
        else
            f_waddr = vs_rdata_reg;
        if (cmd.clear_wr)
        begin
            fw_wdata = '0;
            fn_wdata = '0;
        end
        else if (cmd.push)
        begin
            fw_wdata = {epoch_reg, cnt_w + 1'b1};
            fn_wdata = {epoch_reg, cnt_n + 1'b1};
        end
        else
        begin
            fw_wdata = {epoch_reg, cnt_sel - 1'b1};
            fn_wdata = {epoch_reg, cnt_sel - 1'b1};
        end
    end

    // value store
    always_ff @(posedge clk)
    begin
        if (cmd.lookup)
            value_mem[position_reg[AW-1:0]] <= value_reg;
        if (cmd.rd_val)
            vs_rdata_reg <= value_mem[left_sel[AW-1:0]];
    end

    // wide window frequency table
    always_ff @(posedge clk)
    begin
        if (fw_we)
            freq_w_mem[f_waddr] <= fw_wdata;
        if (fw_re)
            fw_rdata_reg <= freq_w_mem[f_raddr];
    end

    // narrow window frequency table
    always_ff @(posedge clk)
    begin
        if (fn_we)
            freq_n_mem[f_waddr] <= fn_wdata;
        if (fn_re)
            fn_rdata_reg <= freq_n_mem[f_raddr];
    end

    // gap between the two left pointers, saturated
    always_comb
    begin
        narrow_left = k_ge2 ? left_n_reg : position_reg + 1'b1;
        gap         = (narrow_left > left_w_reg) ? narrow_left - left_w_reg : '0;
        gap_ext     = GW'(gap);
        ending_next = (gap_ext > GW'(ENDING_MAX)) ? ENDING_MAX
                                                  : gap_ext[ENDING_BITS-1:0];
    end

    // saturating running total
    always_comb
    begin
        total_sum  = {1'b0, total_reg}
                     + {{(TOTAL_BITS + 1 - ENDING_BITS){1'b0}}, ending_reg};
        total_next = total_sum[TOTAL_BITS] ? TOTAL_MAX : total_sum[TOTAL_BITS-1:0];
    end

    // item payload capture
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
            value_reg <= in_value;
    end

    // sequence state, config and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg          <= K_RESET;
            last_reg       <= 1'b0;
            in_range_reg   <= 1'b0;
            position_reg   <= '0;
            left_w_reg     <= '0;
            left_n_reg     <= '0;
            distinct_w_reg <= '0;
            distinct_n_reg <= '0;
            total_reg      <= '0;
            ovf_reg        <= 1'b0;
            epoch_reg      <= '0;
            clr_addr_reg   <= '0;
            ending_reg     <= '0;
            res_valid_reg  <= 1'b0;
            res_ending_reg <= '0;
            res_total_reg  <= '0;
            res_ovf_reg    <= 1'b0;
            res_done_reg   <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
                k_reg <= cfg.data;

            // clearing sweep
            if (cmd.clear_wr)
                clr_addr_reg <= clr_addr_reg + 1'b1;

            if (cmd.accept)
            begin
                last_reg     <= in_last;
                in_range_reg <= position_reg < PW'(MAX_LEN);
                ending_reg   <= '0;
            end

            // new element enters the wide window, and the narrow one when k is 2 or more
            if (cmd.push)
            begin
                if (cnt_w == '0)
                    distinct_w_reg <= distinct_w_reg + 1'b1;
                if (k_ge2 && (cnt_n == '0))
                    distinct_n_reg <= distinct_n_reg + 1'b1;
            end

            // oldest element leaves the selected window
            if (cmd.dec)
            begin
                if (cmd.win_n)
                begin
                    if (cnt_n == PW'(1))
                        distinct_n_reg <= distinct_n_reg - 1'b1;
                    left_n_reg <= left_n_reg + 1'b1;
                end
                else
                begin
                    if (cnt_w == PW'(1))
                        distinct_w_reg <= distinct_w_reg - 1'b1;
                    left_w_reg <= left_w_reg + 1'b1;
                end
            end

            if (cmd.gap)
                ending_reg <= ending_next;

            // result hand-off
            if (cmd.finish)
            begin
                res_valid_reg  <= 1'b1;
                res_ending_reg <= ending_reg;
                res_total_reg  <= total_next;
                res_ovf_reg    <= ovf_reg | !in_range_reg;
                res_done_reg   <= last_reg;
            end
            else if (result.ready)
                res_valid_reg <= 1'b0;

            // sequence end clears pointers, counts and total, new epoch hides old counts
            if (cmd.finish)
            begin
                if (last_reg)
                begin
                    position_reg   <= '0;
                    left_w_reg     <= '0;
                    left_n_reg     <= '0;
                    distinct_w_reg <= '0;
                    distinct_n_reg <= '0;
                    total_reg      <= '0;
                    ovf_reg        <= 1'b0;
                    epoch_reg      <= epoch_reg + 1'b1;
                end
                else
                begin
                    if (in_range_reg)
                        position_reg <= position_reg + 1'b1;
                    total_reg <= total_next;
                    ovf_reg   <= ovf_reg | !in_range_reg;
                end
            end
        end
    end

    // status to controller
    always_comb
    begin
        status.clear_done = &clr_addr_reg;
        status.in_range   = in_range_reg;
        status.k_ge2      = k_ge2;
        status.shrink_w   = (CMPW'(distinct_w_reg) > CMPW'(k_reg))
                            && (left_w_reg <= position_reg);
        status.shrink_n   = (CMPW'(distinct_n_reg) >= CMPW'(k_reg))
                            && (left_n_reg <= position_reg);
        status.out_free   = !res_valid_reg || result.ready;
        status.last       = last_reg;
        status.epoch_wrap = &epoch_reg;
    end

    assign result.valid         = res_valid_reg;
    assign result.ending_here   = res_ending_reg;
    assign result.running_total = res_total_reg;
    assign result.overflow      = res_ovf_reg;
    assign result.done_res      = res_done_reg;

    // a window never holds more distinct values than elements
    `EKD_ASSERT(a_wide_fits, clk, rst_n, XW'(distinct_w_reg) + XW'(left_w_reg) <= XW'(position_reg) + XW'(1))
    `EKD_ASSERT(a_narrow_fits, clk, rst_n, XW'(distinct_n_reg) + XW'(left_n_reg) <= XW'(position_reg) + XW'(1))

endmodule

// File: sv/exact_k_distinct_subarray_counter.sv
// ----------------------------------------------------------------------------
// exact_k_distinct_subarray_counter
// Counts contiguous subarrays holding exactly k distinct values, using a
// wide (at most k) and a narrow (at most k-1) sliding window.
// ----------------------------------------------------------------------------
// Usage:
//   item   : valid/ready channel, one sequence element per transaction,
//            last marks the final element of a sequence.
//   result : one transaction per item: subarrays ending at that element,
//            running total, overflow and done flag.
//   cfg    : write channel for k, always ready; write only while idle.
// Sequencing:
//   one item is processed at a time; after the item transaction it passes
//   lookup, push, window checks and gap computation (the narrow check is
//   skipped when k is below 2, and past MAX_LEN only the lookup is left)
//   before the result is registered; the next item is taken after that.
//   Each element dropped from a window adds a value store read, a table
//   read, an update and a check; each element leaves a window at most once.
// Reset and stalls:
//   after reset, and after every 256th sequence, a clearing sweep over
//   every entry of both frequency tables runs with item ready low.
//   A stalled result waits in its output register; the block then holds
//   the following item until that register is free.
// ----------------------------------------------------------------------------
module exact_k_distinct_subarray_counter
    import ekd_pkg::*;
#(
    parameter int MAX_LEN    = DEF_MAX_LEN,
    parameter int VALUE_BITS = DEF_VALUE_BITS
) (
    input  logic      clk,
    input  logic      rst_n,
    ekd_in_if.sink    item,
    ekd_out_if.source result,
    ekd_cfg_if.sink   cfg
);

    ekd_cmd_t    cmd;
    ekd_status_t status;
    logic        in_ready;

    assign item.ready = in_ready;

    // sequencer
    ekd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (item.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // tables, counters and result register
    ekd_dp #(
        .MAX_LEN    (MAX_LEN),
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .status   (status),
        .in_value (item.value),
        .in_last  (item.last),
        .cfg      (cfg),
        .result   (result)
    );

endmodule
